/* hw/rtl/bilinear_wrap_texture_sampler_macros.svh */
// Assertion macros shared by the checker of the bilinear texture sampler.
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on aclk and switched off during reset.
`define BWS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and switched off during reset.
`define BWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bws_pkg.sv */
// Shared constants, codes and types of the bilinear texture sampler.
package bws_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int CFG_SIZE_BITS   = 9;
    localparam int CHAN_BITS       = 8;
    localparam int TEXEL_BITS      = 3 * CHAN_BITS;
    localparam int RESULT_BITS     = 17;
    localparam int OUTQ_DEPTH      = 4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] REG_TEX_WIDTH     = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_THREE_CHANNEL = 2'd2;

    localparam logic [1:0] PH_LAST = 2'd3;

    typedef struct packed {
        logic                       valid;
        logic [1:0]                 phase;
        logic [COORD_FRAC_BITS-1:0] wu;
        logic [COORD_FRAC_BITS-1:0] wv;
    } bws_tag_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] red;
        logic [RESULT_BITS-1:0] green;
        logic [RESULT_BITS-1:0] blue;
        logic [RESULT_BITS-1:0] average;
    } bws_result_t;

endpackage

/* hw/rtl/bws_mem.sv */
// Single-port texel memory with a registered read port.
module bws_mem #(
    parameter int DEPTH = bws_pkg::DEF_MAX_WIDTH * bws_pkg::DEF_MAX_HEIGHT,
    parameter int DW    = bws_pkg::TEXEL_BITS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DW-1:0]            wdata,
    output logic [DW-1:0]            rdata
);
    import bws_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bws_front.sv */
// Input stage: takes beats, scales coordinates and sequences the memory port.
module bws_front #(
    parameter int MAX_WIDTH  = bws_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bws_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_kind,
    input  logic [7:0]                               s_texel_x,
    input  logic [7:0]                               s_texel_y,
    input  logic [7:0]                               s_texel_red,
    input  logic [7:0]                               s_texel_green,
    input  logic [7:0]                               s_texel_blue,
    input  logic signed [31:0]                       s_coord_u,
    input  logic signed [31:0]                       s_coord_v,
    input  logic                                     credit_ok,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]           tex_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]          tex_h,
    output logic                                     sample_taken,
    output logic                                     mem_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  mem_addr,
    output logic [bws_pkg::TEXEL_BITS-1:0]           mem_wdata,
    output bws_pkg::bws_tag_t                        tag
);
    import bws_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int UB = $clog2(MAX_WIDTH);
    localparam int VB = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic                  op_valid_reg;
    logic                  op_kind_reg;
    logic                  op_we_reg;
    logic [1:0]            phase_reg;
    logic [7:0]            wx_reg;
    logic [7:0]            wy_reg;
    logic [TEXEL_BITS-1:0] wdata_reg;
    logic [F+WW-1:0]       upix_reg;
    logic [F+HB-1:0]       vpix_reg;

    logic            free;
    logic            accept;
    logic [F-1:0]    uf;
    logic [F-1:0]    vf;
    logic [F+WW-1:0] upix_next;
    logic [F+HB-1:0] vpix_next;
    logic            in_range;
    logic [UB-1:0]   ut;
    logic [UB-1:0]   ut1;
    logic [VB-1:0]   vt;
    logic [VB-1:0]   vt1;
    logic [WW-1:0]   ut_inc;
    logic [HB-1:0]   vt_inc;
    logic [UB-1:0]   x_sel;
    logic [VB-1:0]   y_sel;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    assign free    = !op_valid_reg || (op_kind_reg == KIND_WRITE) || (phase_reg == PH_LAST);
    assign s_ready = free && ((s_kind == KIND_WRITE) || credit_ok);
    assign accept  = s_valid && s_ready;
    assign sample_taken = accept && (s_kind == KIND_SAMPLE);

    assign uf        = s_coord_u[F-1:0];
    assign vf        = {F{1'b0}} - s_coord_v[F-1:0];
    assign upix_next = (F+WW)'(uf) * (F+WW)'(tex_w);
    assign vpix_next = (F+HB)'(vf) * (F+HB)'(tex_h);
    assign in_range  = (32'(s_texel_x) < MAX_WIDTH) && (32'(s_texel_y) < MAX_HEIGHT);

    assign ut     = upix_reg[F+UB-1:F];
    assign vt     = vpix_reg[F+VB-1:F];
    assign ut_inc = WW'(ut) + WW'(1);
    assign vt_inc = HB'(vt) + HB'(1);
    assign ut1    = (ut_inc == tex_w) ? '0 : ut_inc[UB-1:0];
    assign vt1    = (vt_inc == tex_h) ? '0 : vt_inc[VB-1:0];
    assign x_sel  = phase_reg[0] ? ut1 : ut;
    assign y_sel  = phase_reg[1] ? vt1 : vt;

    assign rd_addr = AW'(y_sel) * AW'(MAX_WIDTH) + AW'(x_sel);
    assign wr_addr = AW'(wy_reg) * AW'(MAX_WIDTH) + AW'(wx_reg);

    assign mem_we    = op_valid_reg && (op_kind_reg == KIND_WRITE) && op_we_reg;
    assign mem_addr  = (op_kind_reg == KIND_WRITE) ? wr_addr : rd_addr;
    assign mem_wdata = wdata_reg;

    assign tag.valid = op_valid_reg && (op_kind_reg == KIND_SAMPLE);
    assign tag.phase = phase_reg;
    assign tag.wu    = upix_reg[F-1:0];
    assign tag.wv    = vpix_reg[F-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
            phase_reg    <= 2'd0;
        end else if (accept) begin
            op_valid_reg <= 1'b1;
            phase_reg    <= 2'd0;
        end else if (free) begin
            op_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_kind_reg <= s_kind;
            op_we_reg   <= in_range;
            wx_reg      <= s_texel_x;
            wy_reg      <= s_texel_y;
            wdata_reg   <= {s_texel_blue, s_texel_green, s_texel_red};
            upix_reg    <= upix_next;
            vpix_reg    <= vpix_next;
        end
    end

endmodule

/* hw/rtl/bws_blend.sv */
// Bilinear blend of the four fetched texels and scaling to Q1.16.
module bws_blend (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bws_pkg::bws_tag_t              tag,
    input  logic [bws_pkg::TEXEL_BITS-1:0] rdata,
    input  logic                           three_channel,
    output logic                           push,
    output bws_pkg::bws_result_t           result
);
    import bws_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int HW  = F + CHAN_BITS;
    localparam int VW  = 2 * F + CHAN_BITS;
    localparam int RSH = 2 * F - 16;
    localparam int NW  = CHAN_BITS + 16;
    localparam int NAW = NW + 2;
    localparam int DS  = 26;
    localparam int RB  = RESULT_BITS;
    localparam logic [VW+1:0] HALF    = (VW+2)'(255) << (RSH - 1);
    localparam logic [DS-1:0] RCP_CH  = DS'((64'd1 << DS) / 255);
    localparam logic [DS-1:0] RCP_AVG = DS'((64'd1 << DS) / 765);
    localparam logic [F:0]    ONE     = (F+1)'(1) << F;

    bws_tag_t       tag_d_reg;
    logic           h0_vld_reg;
    logic           h1_vld_reg;
    logic           v1_vld_reg;
    logic           acc_vld_reg;
    logic           n_vld_reg;
    logic           est_vld_reg;
    logic [HW-1:0]  hpart_reg [3];
    logic [HW-1:0]  h0_reg [3];
    logic [HW-1:0]  h1_reg [3];
    logic [F-1:0]   wv0_reg;
    logic [F-1:0]   wv1_reg;
    logic [VW-1:0]  v0_reg [3];
    logic [VW-1:0]  v1_reg [3];
    logic [VW-1:0]  acc_reg [3];
    logic [NW-1:0]  n_reg [3];
    logic [NAW-1:0] navg_reg;
    logic [NW-1:0]  nd_reg [3];
    logic [NAW-1:0] navgd_reg;
    logic [RB-1:0]  est_reg [3];
    logic [RB-1:0]  esta_reg;

    logic [F:0]      weight;
    logic [HW-1:0]   prod [3];
    logic [HW-1:0]   hsum [3];
    logic [VW+1:0]   asum;
    logic [RB-1:0]   fin [3];
    logic [RB-1:0]   fina;
    logic [NW-1:0]   rem [3];
    logic [NAW-1:0]  rema;

    assign weight = tag_d_reg.phase[0] ? {1'b0, tag_d_reg.wu} : ONE - {1'b0, tag_d_reg.wu};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = HW'(rdata[c*CHAN_BITS +: CHAN_BITS]) * HW'(weight);
            hsum[c] = hpart_reg[c] + prod[c];
            rem[c]  = nd_reg[c] - NW'(est_reg[c]) * NW'(255);
            fin[c]  = (rem[c] >= NW'(255)) ? est_reg[c] + RB'(1) : est_reg[c];
        end
        rema = navgd_reg - NAW'(esta_reg) * NAW'(765);
        fina = (rema >= NAW'(765)) ? esta_reg + RB'(1) : esta_reg;
        asum = (VW+2)'(acc_reg[0]) + (VW+2)'(acc_reg[1]) + (VW+2)'(acc_reg[2])
             + HALF + HALF + HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d_reg   <= '0;
            h0_vld_reg  <= 1'b0;
            h1_vld_reg  <= 1'b0;
            v1_vld_reg  <= 1'b0;
            acc_vld_reg <= 1'b0;
            n_vld_reg   <= 1'b0;
            est_vld_reg <= 1'b0;
        end else begin
            tag_d_reg   <= tag;
            h0_vld_reg  <= tag_d_reg.valid && (tag_d_reg.phase == 2'd1);
            h1_vld_reg  <= tag_d_reg.valid && (tag_d_reg.phase == PH_LAST);
            v1_vld_reg  <= h1_vld_reg;
            acc_vld_reg <= v1_vld_reg;
            n_vld_reg   <= acc_vld_reg;
            est_vld_reg <= n_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_d_reg.valid && !tag_d_reg.phase[0]) begin
            hpart_reg <= prod;
        end
        if (tag_d_reg.valid && (tag_d_reg.phase == 2'd1)) begin
            h0_reg  <= hsum;
            wv0_reg <= tag_d_reg.wv;
        end
        if (tag_d_reg.valid && (tag_d_reg.phase == PH_LAST)) begin
            h1_reg  <= hsum;
            wv1_reg <= tag_d_reg.wv;
        end
        for (int c = 0; c < 3; c++) begin
            if (h0_vld_reg) begin
                v0_reg[c] <= VW'(h0_reg[c]) * VW'(ONE - {1'b0, wv0_reg});
            end
            if (h1_vld_reg) begin
                v1_reg[c] <= VW'(h1_reg[c]) * VW'(wv1_reg);
            end
            if (v1_vld_reg) begin
                acc_reg[c] <= v0_reg[c] + v1_reg[c];
            end
            if (acc_vld_reg) begin
                n_reg[c] <= NW'(((VW+2)'(acc_reg[c]) + HALF) >> RSH);
            end
            if (n_vld_reg) begin
                nd_reg[c]  <= n_reg[c];
                est_reg[c] <= RB'(((NW+DS)'(n_reg[c]) * (NW+DS)'(RCP_CH)) >> DS);
            end
        end
        if (acc_vld_reg) begin
            navg_reg <= NAW'(asum >> RSH);
        end
        if (n_vld_reg) begin
            navgd_reg <= navg_reg;
            esta_reg  <= RB'(((NAW+DS)'(navg_reg) * (NAW+DS)'(RCP_AVG)) >> DS);
        end
    end

    assign push           = est_vld_reg;
    assign result.red     = fin[0];
    assign result.green   = three_channel ? fin[1] : fin[0];
    assign result.blue    = three_channel ? fin[2] : fin[0];
    assign result.average = three_channel ? fina : fin[0];

endmodule

/* hw/rtl/bws_outq.sv */
// Small result queue that decouples the blend pipeline from the output channel.
module bws_outq #(
    parameter int DEPTH = bws_pkg::OUTQ_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bws_pkg::bws_result_t push_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bws_pkg::bws_result_t head
);
    import bws_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bws_result_t    entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           pop;

    assign m_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/bilinear_wrap_texture_sampler.sv */
// Top level of the bilinear texture sampler with repeat wrapping.
// A write beat stores one texel through the single-port texel memory; a
// sample beat reads its four neighbouring texels from that port, one per
// cycle, and no new beat is accepted until the last of those reads is issued.
// Up to four results may wait in the output queue while new beats keep being
// accepted; when four samples are outstanding, further sample beats wait. The
// texel memory holds MAX_WIDTH by MAX_HEIGHT texels and is undefined until
// written.
module bilinear_wrap_texture_sampler #(
    parameter int MAX_WIDTH  = bws_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bws_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_texel_x,
    input  logic [7:0]                        s_texel_y,
    input  logic [7:0]                        s_texel_red,
    input  logic [7:0]                        s_texel_green,
    input  logic [7:0]                        s_texel_blue,
    input  logic signed [31:0]                s_coord_u,
    input  logic signed [31:0]                s_coord_v,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bws_pkg::RESULT_BITS-1:0]   m_red,
    output logic [bws_pkg::RESULT_BITS-1:0]   m_green,
    output logic [bws_pkg::RESULT_BITS-1:0]   m_blue,
    output logic [bws_pkg::RESULT_BITS-1:0]   m_average,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import bws_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(OUTQ_DEPTH + 1);

    logic [CFG_SIZE_BITS-1:0] tex_width_reg;
    logic [CFG_SIZE_BITS-1:0] tex_height_reg;
    logic                     three_channel_reg;
    logic [IW-1:0]            inflight_reg;
    logic [IW-1:0]            inflight_next;

    logic                  cfg_write;
    logic [WW-1:0]         tex_w_eff;
    logic [HB-1:0]         tex_h_eff;
    logic                  credit_ok;
    logic                  sample_taken;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [TEXEL_BITS-1:0] mem_wdata;
    logic [TEXEL_BITS-1:0] mem_rdata;
    bws_tag_t              tag;
    logic                  push;
    bws_result_t           push_data;
    bws_result_t           head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg     <= CFG_SIZE_BITS'(256);
            tex_height_reg    <= CFG_SIZE_BITS'(256);
            three_channel_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_TEX_WIDTH:     tex_width_reg     <= pwdata[CFG_SIZE_BITS-1:0];
                REG_TEX_HEIGHT:    tex_height_reg    <= pwdata[CFG_SIZE_BITS-1:0];
                REG_THREE_CHANNEL: three_channel_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TEX_WIDTH:     prdata = 32'(tex_width_reg);
            REG_TEX_HEIGHT:    prdata = 32'(tex_height_reg);
            REG_THREE_CHANNEL: prdata = 32'(three_channel_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        if (tex_width_reg == '0) begin
            tex_w_eff = WW'(1);
        end else if (32'(tex_width_reg) > MAX_WIDTH) begin
            tex_w_eff = WW'(MAX_WIDTH);
        end else begin
            tex_w_eff = WW'(tex_width_reg);
        end
        if (tex_height_reg == '0) begin
            tex_h_eff = HB'(1);
        end else if (32'(tex_height_reg) > MAX_HEIGHT) begin
            tex_h_eff = HB'(MAX_HEIGHT);
        end else begin
            tex_h_eff = HB'(tex_height_reg);
        end
    end

    always_comb begin
        inflight_next = inflight_reg;
        if (sample_taken && !(m_valid && m_ready)) begin
            inflight_next = inflight_reg + IW'(1);
        end else if (!sample_taken && m_valid && m_ready) begin
            inflight_next = inflight_reg - IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    assign credit_ok = (32'(inflight_reg) < OUTQ_DEPTH);

    bws_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_texel_x     (s_texel_x),
        .s_texel_y     (s_texel_y),
        .s_texel_red   (s_texel_red),
        .s_texel_green (s_texel_green),
        .s_texel_blue  (s_texel_blue),
        .s_coord_u     (s_coord_u),
        .s_coord_v     (s_coord_v),
        .credit_ok     (credit_ok),
        .tex_w         (tex_w_eff),
        .tex_h         (tex_h_eff),
        .sample_taken  (sample_taken),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .tag           (tag)
    );

    bws_mem #(
        .DEPTH (DEPTH),
        .DW    (TEXEL_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bws_blend u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tag           (tag),
        .rdata         (mem_rdata),
        .three_channel (three_channel_reg),
        .push          (push),
        .result        (push_data)
    );

    bws_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_red     = head.red;
    assign m_green   = head.green;
    assign m_blue    = head.blue;
    assign m_average = head.average;

endmodule

/* hw/rtl/bws_checker.sv */
// Port-level checker of the bilinear texture sampler and its bind statement.
`include "bilinear_wrap_texture_sampler_macros.svh"

module bws_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [bws_pkg::RESULT_BITS-1:0] m_red,
    input logic [bws_pkg::RESULT_BITS-1:0] m_green,
    input logic [bws_pkg::RESULT_BITS-1:0] m_blue,
    input logic [bws_pkg::RESULT_BITS-1:0] m_average
);
    import bws_pkg::*;

    localparam logic [RESULT_BITS-1:0] FULL_SCALE = RESULT_BITS'(65536);

    `BWS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_red) && $stable(m_green) && $stable(m_blue) && $stable(m_average), "result beat changed while stalled")
    `BWS_ASSERT_HOLDS(a_full_scale, m_valid, (m_red <= FULL_SCALE) && (m_green <= FULL_SCALE) && (m_blue <= FULL_SCALE) && (m_average <= FULL_SCALE), "result above full scale")
    `BWS_ASSERT_HOLDS(a_avg_not_above, m_valid, (m_average <= m_red) || (m_average <= m_green) || (m_average <= m_blue), "average above every channel")
    `BWS_ASSERT_HOLDS(a_avg_not_below, m_valid, (m_average >= m_red) || (m_average >= m_green) || (m_average >= m_blue), "average below every channel")

endmodule

bind bilinear_wrap_texture_sampler bws_checker u_bws_checker (.*);

/* test/bws_scoreboard.sv */
// Checker that predicts filtered samples of the texture sampler and compares the result beats.
module bws_scoreboard (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_kind,
    input  logic [7:0]                      s_texel_x,
    input  logic [7:0]                      s_texel_y,
    input  logic [7:0]                      s_texel_red,
    input  logic [7:0]                      s_texel_green,
    input  logic [7:0]                      s_texel_blue,
    input  logic signed [31:0]              s_coord_u,
    input  logic signed [31:0]              s_coord_v,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [bws_pkg::RESULT_BITS-1:0] m_red,
    input  logic [bws_pkg::RESULT_BITS-1:0] m_green,
    input  logic [bws_pkg::RESULT_BITS-1:0] m_blue,
    input  logic [bws_pkg::RESULT_BITS-1:0] m_average,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output int                              mismatches,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bws_pkg::*;

    logic [TEXEL_BITS-1:0] texels [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    logic [8:0]            width_reg;
    logic [8:0]            height_reg;
    logic                  rgb_mode;
    bws_result_t           samples_due [$];

    assign pending = samples_due.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic bws_result_t filter_sample(input logic [31:0] u, input logic [31:0] v);
        longint unsigned w, h, uf, vf, upix, vpix, wu, wv, dvs, one;
        longint unsigned acc [3];
        longint unsigned wgt [4];
        int unsigned     tx [4];
        int unsigned     ty [4];
        int unsigned     ut, vt;
        logic [23:0]     t;
        bws_result_t     r;
        one = 64'd1 << COORD_FRAC_BITS;
        w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
        uf = u[15:0];
        vf = (one - v[15:0]) & (one - 1);
        upix = uf * w;
        vpix = vf * h;
        ut = upix >> COORD_FRAC_BITS;
        vt = vpix >> COORD_FRAC_BITS;
        wu = upix & (one - 1);
        wv = vpix & (one - 1);
        wgt[0] = (one - wu) * (one - wv);
        wgt[1] = wu * (one - wv);
        wgt[2] = (one - wu) * wv;
        wgt[3] = wu * wv;
        tx[0] = ut;             ty[0] = vt;
        tx[1] = (ut + 1) % w;   ty[1] = vt;
        tx[2] = ut;             ty[2] = (vt + 1) % h;
        tx[3] = (ut + 1) % w;   ty[3] = (vt + 1) % h;
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        for (int k = 0; k < 4; k++) begin
            t = texels[ty[k] * DEF_MAX_WIDTH + tx[k]];
            for (int c = 0; c < 3; c++) acc[c] += longint'(t[8*c +: 8]) * wgt[k];
        end
        dvs = 64'd255 << 16;
        if (rgb_mode) begin
            r.red     = (acc[0] + dvs / 2) / dvs;
            r.green   = (acc[1] + dvs / 2) / dvs;
            r.blue    = (acc[2] + dvs / 2) / dvs;
            r.average = (acc[0] + acc[1] + acc[2] + 3 * dvs / 2) / (3 * dvs);
        end else begin
            r.red     = (acc[0] + dvs / 2) / dvs;
            r.green   = r.red;
            r.blue    = r.red;
            r.average = r.red;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        bws_result_t want;
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            rgb_mode   <= 1'b1;
            mismatches = 0;
            samples_due.delete();
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_TEX_WIDTH:     width_reg  <= pwdata[8:0];
                    REG_TEX_HEIGHT:    height_reg <= pwdata[8:0];
                    REG_THREE_CHANNEL: rgb_mode   <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_WRITE) begin
                    texels[{s_texel_y, s_texel_x}] = {s_texel_blue, s_texel_green, s_texel_red};
                end else begin
                    samples_due.push_back(filter_sample(s_coord_u, s_coord_v));
                end
            end
            if (m_valid && m_ready) begin
                if (samples_due.size() == 0) begin
                    report("unexpected result beat", 0, 0);
                end else begin
                    want = samples_due.pop_front();
                    if (m_red !== want.red) report("red", m_red, want.red);
                    if (m_green !== want.green) report("green", m_green, want.green);
                    if (m_blue !== want.blue) report("blue", m_blue, want.blue);
                    if (m_average !== want.average) report("average", m_average, want.average);
                end
            end
        end
    end
endmodule

/* test/tb_bilinear_wrap_texture_sampler.sv */
// Testbench top of the texture sampler: stimulus, configuration writes and the verdict.
module tb_bilinear_wrap_texture_sampler;
    timeunit 1ns;
    timeprecision 1ps;
    import bws_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_kind;
    logic [7:0]             s_texel_x;
    logic [7:0]             s_texel_y;
    logic [7:0]             s_texel_red;
    logic [7:0]             s_texel_green;
    logic [7:0]             s_texel_blue;
    logic signed [31:0]     s_coord_u;
    logic signed [31:0]     s_coord_v;
    logic                   m_valid;
    logic                   m_ready;
    logic [RESULT_BITS-1:0] m_red;
    logic [RESULT_BITS-1:0] m_green;
    logic [RESULT_BITS-1:0] m_blue;
    logic [RESULT_BITS-1:0] m_average;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    int                     mismatches;
    int                     pending;
    int                     cycles;
    int                     burst_left;
    logic [8:0]             cur_w;
    logic [8:0]             cur_h;

    bilinear_wrap_texture_sampler DUT (.*);
    bws_scoreboard checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 200000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls in runs whose odds are redrawn at random from four modes.
    initial begin
        int mode;
        m_ready = 1'b0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= cycles[3];
            endcase
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(input logic kind, input logic [7:0] x, input logic [7:0] y,
                             input logic [23:0] rgb, input logic [31:0] u,
                             input logic [31:0] v);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_texel_x     <= x;
        s_texel_y     <= y;
        s_texel_red   <= rgb[7:0];
        s_texel_green <= rgb[15:8];
        s_texel_blue  <= rgb[23:16];
        s_coord_u     <= u;
        s_coord_v     <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
    endtask

    // Fills the whole active area, so that every later sample reads written texels.
    task automatic fill_texture(input logic [8:0] w, input logic [8:0] h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_beat(KIND_WRITE, x, y, $urandom, 0, 0);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_beat(KIND_WRITE, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                          $urandom, $urandom, $urandom);
            else
                send_beat(KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic set_size(input logic [8:0] w, input logic [8:0] h, input logic rgb);
        reg_write(REG_TEX_WIDTH, w);
        reg_write(REG_TEX_HEIGHT, h);
        reg_write(REG_THREE_CHANNEL, rgb);
        cur_w = w;
        cur_h = h;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_WRITE;
        s_texel_x = '0;
        s_texel_y = '0;
        s_texel_red = '0;
        s_texel_green = '0;
        s_texel_blue = '0;
        s_coord_u = '0;
        s_coord_v = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        set_size(9'd1, 9'd1, 1'b1);
        send_beat(KIND_WRITE, 8'd0, 8'd0, 24'hFFFFFF, 0, 0);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        set_size(9'd2, 9'd2, 1'b1);
        send_beat(KIND_WRITE, 8'd0, 8'd0, 24'h000000, 0, 0);
        send_beat(KIND_WRITE, 8'd1, 8'd0, 24'hFF00FF, 0, 0);
        send_beat(KIND_WRITE, 8'd0, 8'd1, 24'h00FF00, 0, 0);
        send_beat(KIND_WRITE, 8'd1, 8'd1, 24'h123456, 0, 0);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'h0000_8000, 32'h0000_8000);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'hFFFF_C000, 32'h0001_4000);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'h0000_FFFF, 32'h0000_0001);
        drain();
        reg_write(REG_THREE_CHANNEL, 32'd0);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'h0000_8000, 32'h0000_8000);
        send_beat(KIND_SAMPLE, 0, 0, 0, 32'h8000_4000, 32'h7FFF_C000);
        drain();

        set_size(9'd256, 9'd256, 1'b1);
        send_beat(KIND_WRITE, 8'd255, 8'd255, 24'hABCDEF, 0, 0);
        drain();
        set_size(9'd3, 9'd5, 1'b1);
        fill_texture(3, 5);
        random_phase(150);
        drain();

        set_size(9'd7, 9'd2, 1'b0);
        fill_texture(7, 2);
        random_phase(150);
        drain();

        set_size(9'd16, 9'd1, 1'b1);
        fill_texture(16, 1);
        random_phase(150);
        drain();

        set_size(9'd1, 9'd11, 1'b0);
        fill_texture(1, 11);
        random_phase(150);
        drain();

        set_size(9'd256, 9'd2, 1'b1);
        fill_texture(256, 2);
        random_phase(150);
        drain();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
